// ===== hdl/nsf_pkg.sv =====
// ----------------------------------------------------------------------------
// nsf_pkg
// Constants, register indexes and saturation helpers for the nerve
// stimulation filter.
// ----------------------------------------------------------------------------
package nsf_pkg;

    // defaults for the top level parameters
    localparam int SAMPLE_WIDTH_DEF   = 24;
    localparam int COEF_FRAC_BITS_DEF = 24;

    // fixed formats
    localparam int COEF_W      = 24;   // coefficient registers, unsigned
    localparam int ACC_W       = 48;   // accumulators, signed
    localparam int ACC_HALF    = 24;   // split point of the decay product
    localparam int SAMPLE_FRAC = 16;
    localparam int OUT_FRAC    = 24;
    localparam int OUT_W       = 32;
    localparam int CFG_ADDR_W  = 3;

    // decay product before scaling: coef * acc plus headroom
    localparam int PROD_W = COEF_W + ACC_W + 2;
    // stimulation sum before scaling to the output fraction
    localparam int STIM_W = ACC_W + 12;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GAIN_ONE    = 3'd0,
        REG_DECAY_ONE   = 3'd1,
        REG_GAIN_TWO    = 3'd2,
        REG_DECAY_TWO   = 3'd3,
        REG_GAIN_THREE  = 3'd4,
        REG_DECAY_THREE = 3'd5
    } t_cfg_idx;

    localparam logic [COEF_W-1:0] GAIN_ONE_RST    = 24'd367579;
    localparam logic [COEF_W-1:0] DECAY_ONE_RST   = 24'd13568070;
    localparam logic [COEF_W-1:0] GAIN_TWO_RST    = 24'd2573;
    localparam logic [COEF_W-1:0] DECAY_TWO_RST   = 24'd16721381;
    localparam logic [COEF_W-1:0] GAIN_THREE_RST  = 24'd52782;
    localparam logic [COEF_W-1:0] DECAY_THREE_RST = 24'd16005078;

    localparam logic signed [PROD_W:0] ACC_MAX_W = (PROD_W+1)'(64'sh7FFF_FFFF_FFFF);
    localparam logic signed [PROD_W:0] ACC_MIN_W = -ACC_MAX_W - (PROD_W+1)'(1);

    localparam logic signed [STIM_W-1:0] OUT_MAX_W = STIM_W'(64'sh7FFF_FFFF);
    localparam logic signed [STIM_W-1:0] OUT_MIN_W = -OUT_MAX_W - STIM_W'(1);

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [PROD_W:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > ACC_MAX_W) begin
            r = ACC_MAX_W[ACC_W-1:0];
        end else if (v < ACC_MIN_W) begin
            r = ACC_MIN_W[ACC_W-1:0];
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [STIM_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > OUT_MAX_W) begin
            r = OUT_MAX_W[OUT_W-1:0];
        end else if (v < OUT_MIN_W) begin
            r = OUT_MIN_W[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/nerve_stimulation_filter.sv =====
// ----------------------------------------------------------------------------
// nerve_stimulation_filter
// Single-axis stimulation filter: slew of the gradient waveform feeds three
// first-order exponential accumulators whose signed sum is the output.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_gradient_sample, i_is_last
//  out     | output    | o_out_valid / i_out_ready  | o_stimulation, o_last_out
//  cfg     | input     | i_cfg_we (no wait)         | i_cfg_addr, i_cfg_data
//
// One sample per cycle sustained while the output is not stalled, including
// the extra result of a final sample: it goes out in the slot of the next
// waveform's first sample, which makes no result. A result reaches the output
// register once the following sample is in stage A, a closing result once
// the final sample has passed stages A and B. Gain products are formed
// ahead of the input register; the accumulator recurrence (decay product,
// add, saturate) is combinational. Output stalls freeze stage B and a full
// stage A; synchronous reset clears control and waveform state.
// ----------------------------------------------------------------------------
module nerve_stimulation_filter #(
    parameter int SAMPLE_WIDTH   = nsf_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = nsf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // sample stream
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_gradient_sample,
    input  logic                                 i_is_last,
    // result stream
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [nsf_pkg::OUT_W-1:0]     o_stimulation,
    output logic                                 o_last_out,
    // register writes
    input  logic                                 i_cfg_we,
    input  logic [nsf_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [nsf_pkg::COEF_W-1:0]           i_cfg_data
);

    localparam int DW   = SAMPLE_WIDTH + 1;                  // slew
    localparam int GPW  = nsf_pkg::COEF_W + 1 + DW;          // gain * slew
    localparam int BW   = SAMPLE_WIDTH + 10;                 // scaled gain term
    localparam int PW   = nsf_pkg::PROD_W;
    localparam int SW   = nsf_pkg::STIM_W;
    localparam int SHR  = (COEF_FRAC_BITS >= nsf_pkg::OUT_FRAC) ?
                          (COEF_FRAC_BITS - nsf_pkg::OUT_FRAC) : 0;
    localparam int SHL  = (COEF_FRAC_BITS < nsf_pkg::OUT_FRAC) ?
                          (nsf_pkg::OUT_FRAC - COEF_FRAC_BITS) : 0;

    localparam logic signed [GPW-1:0] RND_G = GPW'((64'sd1 << nsf_pkg::SAMPLE_FRAC) >> 1);
    localparam logic signed [PW-1:0]  RND_D = PW'((64'sd1 << COEF_FRAC_BITS) >> 1);
    localparam logic signed [SW-1:0]  RND_O = SW'((64'sd1 << SHR) >> 1);

    // ------------------------------------------------------------------
    // arithmetic helpers
    // ------------------------------------------------------------------
    // round half up of gain * x / 2^16
    function automatic logic signed [BW-1:0] gain_term(
        input logic [nsf_pkg::COEF_W-1:0] gain,
        input logic signed [DW-1:0]       x
    );
        logic signed [GPW-1:0] p;
        p = $signed({1'b0, gain}) * x;
        p = (p + RND_G) >>> nsf_pkg::SAMPLE_FRAC;
        return p[BW-1:0];
    endfunction

    // decay * acc, acc split in two 24-bit halves, rounded, plus b, saturated
    function automatic logic signed [nsf_pkg::ACC_W-1:0] acc_update(
        input logic signed [nsf_pkg::ACC_W-1:0] acc,
        input logic [nsf_pkg::COEF_W-1:0]       decay,
        input logic signed [BW-1:0]             b
    );
        logic signed [nsf_pkg::ACC_W-nsf_pkg::ACC_HALF-1:0] hi;
        logic [nsf_pkg::ACC_HALF-1:0]                       lo;
        logic signed [nsf_pkg::COEF_W+nsf_pkg::ACC_HALF:0]  p_hi;
        logic [nsf_pkg::COEF_W+nsf_pkg::ACC_HALF-1:0]       p_lo;
        logic signed [PW-1:0]                               sum;
        logic signed [PW:0]                                 tot;
        hi   = acc[nsf_pkg::ACC_W-1:nsf_pkg::ACC_HALF];
        lo   = acc[nsf_pkg::ACC_HALF-1:0];
        p_hi = $signed({1'b0, decay}) * hi;
        p_lo = decay * lo;
        sum  = (PW'(p_hi) <<< nsf_pkg::ACC_HALF) + $signed({2'b00, p_lo}) + RND_D;
        sum  = sum >>> COEF_FRAC_BITS;
        tot  = (PW+1)'(sum) + (PW+1)'(b);
        return nsf_pkg::sat_acc(tot);
    endfunction

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic [nsf_pkg::COEF_W-1:0] r_gain_one, r_decay_one;
    logic [nsf_pkg::COEF_W-1:0] r_gain_two, r_decay_two;
    logic [nsf_pkg::COEF_W-1:0] r_gain_three, r_decay_three;

    logic signed [SAMPLE_WIDTH-1:0] r_prev;
    logic                           r_have_prev;

    // stage A: gain terms of one sample
    logic                   r_a_valid;
    logic                   r_a_hp;      // sample has a predecessor: emits a result
    logic                   r_a_last;
    logic                   r_a_neg;
    logic signed [BW-1:0]   r_b1, r_b2, r_b3;

    // stage B: accumulators
    logic signed [nsf_pkg::ACC_W-1:0] r_acc1, r_acc2, r_acc3;
    logic                             r_due;   // final result of a waveform pending

    // output register
    logic                              r_ov;
    logic signed [nsf_pkg::OUT_W-1:0]  r_stim;
    logic                              r_olast;

    // ------------------------------------------------------------------
    // flow control
    // ------------------------------------------------------------------
    logic adv;
    logic in_xfer;
    logic b_fire;

    assign adv        = !r_ov || i_out_ready;
    assign o_in_ready = !r_a_valid || adv;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign b_fire     = adv && r_a_valid;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_one    <= nsf_pkg::GAIN_ONE_RST;
            r_decay_one   <= nsf_pkg::DECAY_ONE_RST;
            r_gain_two    <= nsf_pkg::GAIN_TWO_RST;
            r_decay_two   <= nsf_pkg::DECAY_TWO_RST;
            r_gain_three  <= nsf_pkg::GAIN_THREE_RST;
            r_decay_three <= nsf_pkg::DECAY_THREE_RST;
        end else if (i_cfg_we) begin
            case (nsf_pkg::t_cfg_idx'(i_cfg_addr))
                nsf_pkg::REG_GAIN_ONE:    r_gain_one    <= i_cfg_data;
                nsf_pkg::REG_DECAY_ONE:   r_decay_one   <= i_cfg_data;
                nsf_pkg::REG_GAIN_TWO:    r_gain_two    <= i_cfg_data;
                nsf_pkg::REG_DECAY_TWO:   r_decay_two   <= i_cfg_data;
                nsf_pkg::REG_GAIN_THREE:  r_gain_three  <= i_cfg_data;
                nsf_pkg::REG_DECAY_THREE: r_decay_three <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage A: slew and gain products
    // ------------------------------------------------------------------
    logic signed [DW-1:0] n_slew;
    logic signed [DW-1:0] n_mag;
    logic signed [BW-1:0] n_b1, n_b2, n_b3;

    always_comb begin
        n_slew = DW'(i_gradient_sample) - DW'(r_prev);
        n_mag  = n_slew[DW-1] ? -n_slew : n_slew;
        n_b1   = gain_term(r_gain_one, n_slew);
        n_b2   = gain_term(r_gain_two, n_mag);
        n_b3   = gain_term(r_gain_three, n_slew);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_have_prev <= 1'b0;
            r_prev      <= '0;
        end else begin
            if (o_in_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (in_xfer) begin
                r_have_prev <= !i_is_last;
                r_prev      <= i_is_last ? '0 : i_gradient_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a_hp   <= r_have_prev;
            r_a_last <= i_is_last;
            r_a_neg  <= n_slew[DW-1];
            r_b1     <= n_b1;
            r_b2     <= n_b2;
            r_b3     <= n_b3;
        end
    end

    // ------------------------------------------------------------------
    // stage B: accumulator recurrence
    // ------------------------------------------------------------------
    // A sample without predecessor starts a waveform, so its accumulators
    // are zero. After a final sample the updated values are held for the pending
    // result; the next sample is always a first one.
    logic signed [nsf_pkg::ACC_W-1:0] n_acc1, n_acc2, n_acc3;

    always_comb begin
        if (r_a_hp) begin
            n_acc1 = acc_update(r_acc1, r_decay_one, r_b1);
            n_acc2 = acc_update(r_acc2, r_decay_two, r_b2);
            n_acc3 = acc_update(r_acc3, r_decay_three, r_b3);
        end else begin
            n_acc1 = '0;
            n_acc2 = '0;
            n_acc3 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc1 <= '0;
            r_acc2 <= '0;
            r_acc3 <= '0;
        end else if (b_fire) begin
            r_acc1 <= n_acc1;
            r_acc2 <= n_acc2;
            r_acc3 <= n_acc3;
        end
    end

    // ------------------------------------------------------------------
    // stimulation sum and output register
    // ------------------------------------------------------------------
    // the pending final result takes sign +1; otherwise the slew sign
    logic                              n_neg;
    logic signed [SW-1:0]              n_sum;
    logic signed [nsf_pkg::OUT_W-1:0]  n_stim;

    always_comb begin
        n_neg  = !r_due && r_a_neg;
        n_sum  = SW'(r_acc1) + SW'(r_acc3) + (n_neg ? -SW'(r_acc2) : SW'(r_acc2));
        n_sum  = ((n_sum <<< SHL) + RND_O) >>> SHR;
        n_stim = nsf_pkg::sat_out(n_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_due <= 1'b0;
        end else if (adv) begin
            r_ov  <= r_due || (r_a_valid && r_a_hp);
            r_due <= r_a_valid && r_a_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_stim  <= n_stim;
            r_olast <= r_due;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_stimulation = r_stim;
    assign o_last_out    = r_olast;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nerve stimulation filter. Waveforms of gradient
// samples are sent with random gaps and results are drained under random
// back-pressure. A bit-accurate copy of the filter, run on every accepted
// sample, supplies the expected stimulation values.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SAMPLE_W      = nsf_pkg::SAMPLE_WIDTH_DEF;
    localparam int COEF_FRAC     = nsf_pkg::COEF_FRAC_BITS_DEF;
    localparam int CFG_ADDR_W    = nsf_pkg::CFG_ADDR_W;
    localparam int COEF_W        = nsf_pkg::COEF_W;
    localparam int OUT_W         = nsf_pkg::OUT_W;
    localparam int OUT_FRAC      = nsf_pkg::OUT_FRAC;
    localparam int SAMPLE_FRAC   = nsf_pkg::SAMPLE_FRAC;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_REPORTS   = 10;
    localparam int NUM_REGS      = 6;

    // unmapped register indexes, writes must be ignored
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

    localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam longint ACC_LIMIT  = 64'sh7FFF_FFFF_FFFF;
    localparam longint OUT_LIMIT  = 64'sd2147483647;
    localparam logic [COEF_W-1:0] COEF_MAX = '1;

    typedef enum int {
        WAVE_RANDOM,
        WAVE_WALK,
        WAVE_TRAPEZOID,
        WAVE_EXTREME,
        WAVE_NOISE
    } t_wave_kind;

    typedef struct {
        logic signed [SAMPLE_W-1:0] grad;
        logic                       last;
    } t_sample;

    typedef struct {
        logic signed [OUT_W-1:0] stim;
        logic                    last;
    } t_stim_result;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        o_in_ready;
    logic signed [SAMPLE_W-1:0]  grad_drv = '0;
    logic                        last_drv = 1'b0;
    logic                        o_out_valid;
    logic                        out_ready = 1'b0;
    logic signed [OUT_W-1:0]     o_stimulation;
    logic                        o_last_out;
    logic                        cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]       cfg_addr = '0;
    logic [COEF_W-1:0]           cfg_data = '0;

    nerve_stimulation_filter #(
        .SAMPLE_WIDTH   (SAMPLE_W),
        .COEF_FRAC_BITS (COEF_FRAC)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_gradient_sample (grad_drv),
        .i_is_last         (last_drv),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_stimulation     (o_stimulation),
        .o_last_out        (o_last_out),
        .i_cfg_we          (cfg_we),
        .i_cfg_addr        (cfg_addr),
        .i_cfg_data        (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // filter copy: coefficients and waveform state
    logic [COEF_W-1:0] coef [NUM_REGS];
    longint            prev_grad;
    bit                have_prev;
    longint            acc_one, acc_two, acc_three;

    t_sample      sample_queue [$];
    t_stim_result stim_expected [$];
    t_sample      head;
    t_stim_result want;

    int  samples_queued, samples_taken, results_seen, waveforms;
    int  mismatches, out_saturations, settings_used, cycles;
    int  send_gap, recv_stall;
    bit  src_throttle = 1'b1;
    bit  sink_throttle = 1'b1;
    bit  open_wave;

    // round half up of coef * v / 2^s
    function automatic longint scale_round(longint c, longint v, int s);
        longint low;
        if (s == 0) return c * v;
        low = v & ((64'sd1 <<< s) - 1);
        return c * (v >>> s) + ((c * low + (64'sd1 <<< (s - 1))) >>> s);
    endfunction

    function automatic longint exp_term(longint acc, longint decay, longint gain, longint x);
        longint v;
        v = scale_round(decay, acc, COEF_FRAC) + scale_round(gain, x, SAMPLE_FRAC);
        if (v > ACC_LIMIT) v = ACC_LIMIT;
        if (v < -ACC_LIMIT - 1) v = -ACC_LIMIT - 1;
        return v;
    endfunction

    function automatic logic signed [OUT_W-1:0] stim_of(bit negative);
        longint s;
        s = acc_one + acc_three + (negative ? -acc_two : acc_two);
        if (COEF_FRAC >= OUT_FRAC) s = scale_round(64'sd1, s, COEF_FRAC - OUT_FRAC);
        else s = s <<< (OUT_FRAC - COEF_FRAC);
        if (s > OUT_LIMIT || s < -OUT_LIMIT - 1) out_saturations++;
        if (s > OUT_LIMIT) s = OUT_LIMIT;
        if (s < -OUT_LIMIT - 1) s = -OUT_LIMIT - 1;
        return s[OUT_W-1:0];
    endfunction

    // one accepted sample: the pending sample's result if any, then the closing one for a final sample
    task automatic filter_step(logic signed [SAMPLE_W-1:0] g_in, logic is_last);
        longint g, d, mag;
        t_stim_result r;
        g = longint'(g_in);
        if (have_prev) begin
            d = g - prev_grad;
            mag = d < 0 ? -d : d;
            r.stim = stim_of(d < 0);
            r.last = 1'b0;
            stim_expected.push_back(r);
            acc_one   = exp_term(acc_one, longint'(coef[nsf_pkg::REG_DECAY_ONE]),
                                 longint'(coef[nsf_pkg::REG_GAIN_ONE]), d);
            acc_two   = exp_term(acc_two, longint'(coef[nsf_pkg::REG_DECAY_TWO]),
                                 longint'(coef[nsf_pkg::REG_GAIN_TWO]), mag);
            acc_three = exp_term(acc_three, longint'(coef[nsf_pkg::REG_DECAY_THREE]),
                                 longint'(coef[nsf_pkg::REG_GAIN_THREE]), d);
        end
        if (is_last) begin
            r.stim = stim_of(1'b0);
            r.last = 1'b1;
            stim_expected.push_back(r);
            prev_grad = 0;
            have_prev = 1'b0;
            acc_one   = 0;
            acc_two   = 0;
            acc_three = 0;
        end else begin
            prev_grad = g;
            have_prev = 1'b1;
        end
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                filter_step(grad_drv, last_drv);
                samples_taken++;
            end
            if (in_valid && !o_in_ready) begin
                // hold the payload until the transfer
            end else if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
                head = sample_queue.pop_front();
                grad_drv <= head.grad;
                last_drv <= head.last;
                in_valid <= 1'b1;
                if ($urandom_range(0, 39) == 0) src_throttle = !src_throttle;
                send_gap = src_throttle ? int'($urandom_range(0, 19)) : 0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                results_seen++;
                if (stim_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] unexpected result: stim %0d last %0b",
                                 $realtime, o_stimulation, o_last_out);
                end else begin
                    want = stim_expected.pop_front();
                    if (o_stimulation !== want.stim || o_last_out !== want.last) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("[%0t] result %0d: stim exp %0d got %0d, last exp %0b got %0b",
                                     $realtime, results_seen, want.stim, o_stimulation,
                                     want.last, o_last_out);
                    end
                end
                if ($urandom_range(0, 39) == 0) sink_throttle = !sink_throttle;
                recv_stall = sink_throttle ? int'($urandom_range(0, 19)) : 0;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, stim_expected.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [COEF_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= data;
        if (idx < NUM_REGS) coef[idx] = data;
    endtask

    task automatic load_coefs(logic [COEF_W-1:0] g1, logic [COEF_W-1:0] d1,
                              logic [COEF_W-1:0] g2, logic [COEF_W-1:0] d2,
                              logic [COEF_W-1:0] g3, logic [COEF_W-1:0] d3);
        write_reg(nsf_pkg::REG_GAIN_ONE, g1);
        write_reg(nsf_pkg::REG_DECAY_ONE, d1);
        write_reg(nsf_pkg::REG_GAIN_TWO, g2);
        write_reg(nsf_pkg::REG_DECAY_TWO, d2);
        write_reg(nsf_pkg::REG_GAIN_THREE, g3);
        write_reg(nsf_pkg::REG_DECAY_THREE, d3);
        // spare indexes last, so an aliased write would corrupt a live register
        write_reg(REG_SPARE_A, COEF_W'($urandom));
        write_reg(REG_SPARE_B, COEF_W'($urandom));
        @(posedge i_clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [COEF_W-1:0] rand_coef(bit is_decay);
        logic [COEF_W-1:0] c;
        case ($urandom_range(0, 3))
            0: c = COEF_W'($urandom);
            1: c = $urandom_range(0, 1) ? COEF_MAX : '0;
            default: c = is_decay ? COEF_MAX - COEF_W'($urandom_range(0, 1 << 20))
                                  : COEF_W'($urandom_range(0, 1 << 20));
        endcase
        return c;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clamp_sample(longint v);
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        if (v < SAMPLE_MIN) v = SAMPLE_MIN;
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic push_sample(longint g, bit is_last);
        t_sample s;
        s.grad = clamp_sample(g);
        s.last = is_last;
        sample_queue.push_back(s);
        samples_queued++;
        open_wave = !is_last;
        if (is_last) waveforms++;
    endtask

    task automatic queue_waveform(t_wave_kind kind, int len);
        longint g, slope;
        logic signed [SAMPLE_W-1:0] raw;
        int k;
        raw = SAMPLE_W'($urandom);
        g = (kind == WAVE_TRAPEZOID) ? 64'sd0 : longint'(raw);
        slope = longint'($urandom_range(0, 1 << $urandom_range(0, 20)));
        for (k = 0; k < len; k++) begin
            case (kind)
                WAVE_RANDOM, WAVE_NOISE: begin
                    raw = SAMPLE_W'($urandom);
                    g = longint'(raw);
                end
                WAVE_WALK: g = g + longint'($urandom_range(0, 32'(2 * slope))) - slope;
                WAVE_TRAPEZOID: begin
                    if (k < len / 3) g = g + slope;
                    else if (k >= len - len / 3) g = g - slope;
                end
                default: begin
                    case ($urandom_range(0, 2))
                        0: g = SAMPLE_MAX;
                        1: g = SAMPLE_MIN;
                        default: g = 0;
                    endcase
                end
            endcase
            if (kind == WAVE_NOISE)
                push_sample(g, k == len - 1 || $urandom_range(0, 9) == 0);
            else
                push_sample(g, k == len - 1);
        end
    endtask

    task automatic queue_random_samples(int count);
        int target, len;
        t_wave_kind kind;
        target = samples_queued + count;
        while (samples_queued < target) begin
            case ($urandom_range(0, 9))
                0:       kind = WAVE_RANDOM;
                1:       kind = WAVE_NOISE;
                2:       kind = WAVE_EXTREME;
                3, 4, 5: kind = WAVE_WALK;
                default: kind = WAVE_TRAPEZOID;
            endcase
            case ($urandom_range(0, 19))
                0, 1:    len = 1;
                2:       len = int'($urandom_range(33, 64));
                default: len = int'($urandom_range(2, 32));
            endcase
            queue_waveform(kind, len);
        end
        if (open_wave) push_sample(0, 1'b1);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (samples_taken != samples_queued || stim_expected.size() != 0);
        // a first sample makes no result, give the pipeline time to settle
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int p;
        coef[nsf_pkg::REG_GAIN_ONE]    = nsf_pkg::GAIN_ONE_RST;
        coef[nsf_pkg::REG_DECAY_ONE]   = nsf_pkg::DECAY_ONE_RST;
        coef[nsf_pkg::REG_GAIN_TWO]    = nsf_pkg::GAIN_TWO_RST;
        coef[nsf_pkg::REG_DECAY_TWO]   = nsf_pkg::DECAY_TWO_RST;
        coef[nsf_pkg::REG_GAIN_THREE]  = nsf_pkg::GAIN_THREE_RST;
        coef[nsf_pkg::REG_DECAY_THREE] = nsf_pkg::DECAY_THREE_RST;
        settings_used = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single-sample waveforms, full-scale slews both ways,
        // flat stretch, small negative and positive slews
        push_sample(0, 1'b1);
        push_sample(SAMPLE_MAX, 1'b1);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MAX, 1'b1);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b1);
        push_sample(100, 1'b0);
        push_sample(100, 1'b0);
        push_sample(100, 1'b1);
        push_sample(0, 1'b0);
        push_sample(-1, 1'b0);
        push_sample(-2, 1'b0);
        push_sample(5, 1'b1);
        wait_idle();
        queue_random_samples(250);
        wait_idle();

        load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        queue_waveform(WAVE_EXTREME, 24);
        queue_random_samples(200);
        wait_idle();

        load_coefs('0, '0, '0, '0, '0, '0);
        queue_random_samples(100);
        wait_idle();

        for (p = 0; p < 4; p++) begin
            load_coefs(rand_coef(1'b0), rand_coef(1'b1), rand_coef(1'b0),
                       rand_coef(1'b1), rand_coef(1'b0), rand_coef(1'b1));
            queue_random_samples(200);
            wait_idle();
        end

        $display("%0d samples in %0d waveforms under %0d coefficient settings",
                 samples_taken, waveforms, settings_used);
        $display("%0d results checked, %0d saturated, %0d mismatches",
                 results_seen, out_saturations, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
